/* hw/rtl/jsu_pkg.sv */
// ----------------------------------------------------------------------------
// jsu_pkg
// shared types, codes and utf-8 helpers for the json string unescaper
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int unsigned RUN_MAX   = 5;
  localparam int unsigned RUN_N_W   = 3;
  localparam int unsigned BUF_DEPTH = 8;
  localparam int unsigned BUF_CNT_W = 4;
  localparam int unsigned LIM_W     = 24;
  localparam int unsigned CP_W      = 21;

  typedef enum logic [2:0] {
    M_WAIT   = 3'd0,
    M_STR    = 3'd1,
    M_ESC    = 3'd2,
    M_HEXHI  = 3'd3,
    M_PAIRBS = 3'd4,
    M_PAIRU  = 3'd5,
    M_HEXLO  = 3'd6
  } mode_e;

  localparam logic [3:0] ST_DATA      = 4'd0;
  localparam logic [3:0] ST_DONE      = 4'd1;
  localparam logic [3:0] ST_NO_QUOTE  = 4'd2;
  localparam logic [3:0] ST_CTRL      = 4'd3;
  localparam logic [3:0] ST_TRUNC_ESC = 4'd4;
  localparam logic [3:0] ST_BAD_HEX   = 4'd5;
  localparam logic [3:0] ST_BAD_SURR  = 4'd6;
  localparam logic [3:0] ST_BAD_ESC   = 4'd7;
  localparam logic [3:0] ST_UNTERM    = 4'd8;
  localparam logic [3:0] ST_TOO_LARGE = 4'd9;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic [15:0] HI_SURR_LO = 16'hD800;
  localparam logic [15:0] HI_SURR_HI = 16'hDBFF;
  localparam logic [15:0] LO_SURR_LO = 16'hDC00;
  localparam logic [15:0] LO_SURR_HI = 16'hDFFF;
  localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [3:0] status;
    logic       last;
  } res_t;

  typedef res_t [RUN_MAX-1:0] run_t;

  // {valid, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

  function automatic logic [2:0] utf8_len(input logic [CP_W-1:0] cp);
    logic [2:0] n;
    if (cp < 21'h80) begin
      n = 3'd1;
    end else if (cp < 21'h800) begin
      n = 3'd2;
    end else if (cp < 21'h10000) begin
      n = 3'd3;
    end else begin
      n = 3'd4;
    end
    return n;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp, input logic [1:0] idx);
    logic [7:0] b;
    b = '0;
    case (utf8_len(cp))
      3'd1: b = cp[7:0];
      3'd2: b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      3'd3: begin
        case (idx)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        case (idx)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

/* hw/rtl/jsu_decode.sv */
// ----------------------------------------------------------------------------
// jsu_decode
// session state and single-pass decode of one raw byte into a run of results
// ----------------------------------------------------------------------------
module jsu_decode import jsu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic [7:0]       in_byte_i,
  input  logic             eoi_i,
  input  logic [LIM_W-1:0] max_i,
  output run_t             run_o,
  output logic [RUN_N_W-1:0] run_n_o
);

  typedef struct packed {
    logic             ovf;
    logic [LIM_W-1:0] cnt;
  } cnt_st_t;

  function automatic cnt_st_t charge(input logic [LIM_W-1:0] cnt, input logic ovf,
                                     input logic [2:0] n, input logic en,
                                     input logic [LIM_W-1:0] lim);
    logic [LIM_W:0] sum;
    cnt_st_t r;
    sum   = {1'b0, cnt} + {{(LIM_W-2){1'b0}}, n};
    r.ovf = ovf;
    r.cnt = cnt;
    if (en && !ovf) begin
      if (sum > {1'b0, lim}) begin
        r.ovf = 1'b1;
      end else begin
        r.cnt = sum[LIM_W-1:0];
      end
    end
    return r;
  endfunction

  mode_e            mode_q, mode_d;
  logic [1:0]       hcnt_q, hcnt_d;
  logic [15:0]      hi_q, hi_d;
  logic [15:0]      lo_q, lo_d;
  logic [LIM_W-1:0] ocnt_q, ocnt_d;
  logic             ovf_q, ovf_d;

  logic [4:0]       hv;
  logic [15:0]      hi_shift, lo_shift;
  logic             cp_en;
  logic [CP_W-1:0]  cp;
  logic [2:0]       ncp;
  logic             data_en;
  logic [7:0]       data_b;
  logic             st_en;
  logic [3:0]       st;
  logic             tail_str, tail_esc, sess_clr, esc_hit;
  logic [7:0]       esc_b;
  cnt_st_t          ch1, ch2;
  logic [2:0]       n_all;
  logic [2:0]       pos_st;

  assign hv       = hex_val(in_byte_i);
  assign hi_shift = {hi_q[11:0], hv[3:0]};
  assign lo_shift = {lo_q[11:0], hv[3:0]};

  always_comb begin
    mode_d   = mode_q;
    hcnt_d   = hcnt_q;
    hi_d     = hi_q;
    lo_d     = lo_q;
    cp_en    = 1'b0;
    cp       = {5'b0, hi_q};
    data_en  = 1'b0;
    data_b   = in_byte_i;
    st_en    = 1'b0;
    st       = ST_DATA;
    tail_str = 1'b0;
    tail_esc = 1'b0;
    sess_clr = 1'b0;
    esc_hit  = 1'b0;
    esc_b    = in_byte_i;

    case (mode_q)
      M_STR: tail_str = 1'b1;
      M_ESC: tail_esc = 1'b1;
      M_HEXHI: begin
        if (!hv[4]) begin
          st_en = 1'b1;
          st    = ST_BAD_HEX;
        end else begin
          hi_d = hi_shift;
          if (hcnt_q != 2'd3) begin
            hcnt_d = hcnt_q + 2'd1;
            if (eoi_i) begin
              st_en = 1'b1;
              st    = ST_BAD_HEX;
            end
          end else begin
            hcnt_d = 2'd0;
            if (hi_shift >= HI_SURR_LO && hi_shift <= HI_SURR_HI && !eoi_i) begin
              mode_d = M_PAIRBS;
            end else begin
              cp_en  = 1'b1;
              cp     = {5'b0, hi_shift};
              mode_d = M_STR;
              if (eoi_i) begin
                st_en = 1'b1;
                st    = ST_UNTERM;
              end
            end
          end
        end
      end
      M_PAIRBS: begin
        if (in_byte_i == CH_BSLASH && !eoi_i) begin
          mode_d = M_PAIRU;
        end else begin
          cp_en    = 1'b1;
          mode_d   = M_STR;
          tail_str = 1'b1;
        end
      end
      M_PAIRU: begin
        if (in_byte_i == CH_U && !eoi_i) begin
          mode_d = M_HEXLO;
          hcnt_d = 2'd0;
          lo_d   = '0;
        end else begin
          cp_en    = 1'b1;
          mode_d   = M_STR;
          tail_esc = 1'b1;
        end
      end
      M_HEXLO: begin
        if (!hv[4]) begin
          st_en = 1'b1;
          st    = ST_BAD_SURR;
        end else begin
          lo_d = lo_shift;
          if (hcnt_q != 2'd3) begin
            hcnt_d = hcnt_q + 2'd1;
            if (eoi_i) begin
              st_en = 1'b1;
              st    = ST_BAD_SURR;
            end
          end else begin
            hcnt_d = 2'd0;
            if (lo_shift < LO_SURR_LO || lo_shift > LO_SURR_HI) begin
              st_en = 1'b1;
              st    = ST_BAD_SURR;
            end else begin
              cp_en  = 1'b1;
              cp     = SUPP_BASE + {1'b0, hi_q[9:0], lo_shift[9:0]};
              mode_d = M_STR;
              if (eoi_i) begin
                st_en = 1'b1;
                st    = ST_UNTERM;
              end
            end
          end
        end
      end
      default: begin
        if (in_byte_i == CH_QUOTE) begin
          sess_clr = 1'b1;
          mode_d   = M_STR;
          if (eoi_i) begin
            st_en = 1'b1;
            st    = ST_UNTERM;
          end
        end else begin
          st_en = 1'b1;
          st    = ST_NO_QUOTE;
        end
      end
    endcase

    ncp = cp_en ? utf8_len(cp) : 3'd0;
    ch1 = charge(ocnt_q, ovf_q, ncp, cp_en, max_i);

    if (tail_str) begin
      if (in_byte_i == CH_QUOTE) begin
        st_en = 1'b1;
        st    = ch1.ovf ? ST_TOO_LARGE : ST_DONE;
      end else if (in_byte_i < CH_SPACE) begin
        st_en = 1'b1;
        st    = ST_CTRL;
      end else if (in_byte_i == CH_BSLASH) begin
        if (eoi_i) begin
          st_en = 1'b1;
          st    = ST_TRUNC_ESC;
        end else begin
          mode_d = M_ESC;
        end
      end else begin
        data_en = 1'b1;
        if (eoi_i) begin
          st_en = 1'b1;
          st    = ST_UNTERM;
        end
      end
    end

    if (tail_esc) begin
      case (in_byte_i)
        CH_QUOTE, CH_BSLASH, CH_SLASH: esc_hit = 1'b1;
        CH_B: begin esc_hit = 1'b1; esc_b = 8'h08; end
        CH_F: begin esc_hit = 1'b1; esc_b = 8'h0C; end
        CH_N: begin esc_hit = 1'b1; esc_b = 8'h0A; end
        CH_R: begin esc_hit = 1'b1; esc_b = 8'h0D; end
        CH_T: begin esc_hit = 1'b1; esc_b = 8'h09; end
        CH_U: begin
          if (eoi_i) begin
            st_en = 1'b1;
            st    = ST_BAD_HEX;
          end else begin
            mode_d = M_HEXHI;
            hcnt_d = 2'd0;
            hi_d   = '0;
          end
        end
        default: begin
          st_en = 1'b1;
          st    = ST_BAD_ESC;
        end
      endcase
      if (esc_hit) begin
        data_en = 1'b1;
        data_b  = esc_b;
        mode_d  = M_STR;
        if (eoi_i) begin
          st_en = 1'b1;
          st    = ST_UNTERM;
        end
      end
    end

    ch2    = charge(ch1.cnt, ch1.ovf, 3'd1, data_en, max_i);
    ocnt_d = ch2.cnt;
    ovf_d  = ch2.ovf;

    if (st_en) begin
      mode_d = M_WAIT;
    end
    if (st_en || sess_clr) begin
      hcnt_d = '0;
      hi_d   = '0;
      lo_d   = '0;
      ocnt_d = '0;
      ovf_d  = 1'b0;
    end
  end

  // run assembly: code point bytes, then the data byte, then the status
  always_comb begin
    n_all  = ncp + {2'b0, data_en} + {2'b0, st_en};
    pos_st = ncp + {2'b0, data_en};
    for (int i = 0; i < RUN_MAX; i++) begin
      run_o[i] = '0;
      if (3'(i) < ncp) begin
        run_o[i].out_byte   = utf8_byte(cp, 2'(i));
        run_o[i].byte_valid = 1'b1;
      end else if (data_en && 3'(i) == ncp) begin
        run_o[i].out_byte   = data_b;
        run_o[i].byte_valid = 1'b1;
      end else if (st_en && 3'(i) == pos_st) begin
        run_o[i].status = st;
      end
      run_o[i].last = (3'(i) + 3'd1 == n_all);
    end
  end

  assign run_n_o = n_all;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_WAIT;
      hcnt_q <= '0;
      hi_q   <= '0;
      lo_q   <= '0;
      ocnt_q <= '0;
      ovf_q  <= 1'b0;
    end else if (adv_i) begin
      mode_q <= mode_d;
      hcnt_q <= hcnt_d;
      hi_q   <= hi_d;
      lo_q   <= lo_d;
      ocnt_q <= ocnt_d;
      ovf_q  <= ovf_d;
    end
  end

`ifndef SYNTHESIS
  a_run_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i |-> (run_n_o <= 3'(RUN_MAX)))
    else $error("run longer than five results");

  a_status_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && st_en) |=> (mode_q == M_WAIT && ocnt_q == '0 && !ovf_q))
    else $error("session not cleared after status");

  a_ovf_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && ovf_q && !st_en && !sess_clr) |=> ($stable(ocnt_q) && ovf_q))
    else $error("count moved after overflow");
`endif

endmodule

/* hw/rtl/jsu_out_buf.sv */
// ----------------------------------------------------------------------------
// jsu_out_buf
// shifting result buffer: whole run in at once; if ready, one word out a cycle
// ----------------------------------------------------------------------------
module jsu_out_buf import jsu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  run_t               run_i,
  input  logic [RUN_N_W-1:0] run_n_i,
  output logic               room_o,
  output logic               valid_o,
  input  logic               ready_i,
  output res_t               head_o
);

  res_t                 slot_q [BUF_DEPTH];
  res_t                 slot_d [BUF_DEPTH];
  logic [BUF_CNT_W-1:0] cnt_q, cnt_d;
  logic [BUF_CNT_W-1:0] base;
  logic [BUF_CNT_W-1:0] off;
  logic                 pop;

  assign valid_o = (cnt_q != '0);
  assign head_o  = slot_q[0];
  assign pop     = valid_o && ready_i;
  assign room_o  = ({1'b0, cnt_q} + {{(BUF_CNT_W-RUN_N_W+1){1'b0}}, run_n_i})
                   <= (BUF_CNT_W+1)'(BUF_DEPTH);

  always_comb begin
    base = cnt_q - {{(BUF_CNT_W-1){1'b0}}, pop};
    off  = '0;
    for (int j = 0; j < BUF_DEPTH; j++) begin
      slot_d[j] = slot_q[j];
    end
    if (pop) begin
      for (int j = 0; j < BUF_DEPTH - 1; j++) begin
        slot_d[j] = slot_q[j+1];
      end
    end
    if (push_i) begin
      for (int j = 0; j < BUF_DEPTH; j++) begin
        off = BUF_CNT_W'(j) - base;
        if (BUF_CNT_W'(j) >= base && off < {{(BUF_CNT_W-RUN_N_W){1'b0}}, run_n_i}) begin
          slot_d[j] = run_i[off[RUN_N_W-1:0]];
        end
      end
    end
    cnt_d = base + (push_i ? {{(BUF_CNT_W-RUN_N_W){1'b0}}, run_n_i} : '0);
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < BUF_DEPTH; j++) begin
      slot_q[j] <= slot_d[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= BUF_CNT_W'(BUF_DEPTH))
    else $error("buffer count past depth");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push_i) |=> (cnt_q == $past(cnt_q) - 1'b1))
    else $error("count wrong after pop");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !head_o.byte_valid) |-> head_o.last)
    else $error("status word not last of its run");
`endif

endmodule

/* hw/rtl/json_string_unescape_utf8.sv */
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// decodes a quoted json string, one raw byte per word, into utf-8 bytes
// ----------------------------------------------------------------------------
// Input stream: one raw byte per word, opening quote first; tlast marks the
// last byte of available input. Output stream: one word per decoded byte,
// then one status word (done or an error code) that closes the string;
// tlast marks the final word caused by one input byte. A byte may cause
// zero to five output words. A string that closes with an error status is
// to be discarded by the consumer.
// A byte is registered at the input, then decoded, and its run is written into
// the registered result buffer, whose head drives the output stream.
// Throughput: one input byte per cycle while its run fits in the buffer; the
// eight-word result buffer absorbs runs of up to five words, and input
// stalls only when a whole run does not fit in it.
// When the receiver stalls the buffer fills and then input tready drops;
// nothing is lost. Reset empties the buffer, waits for an opening quote and
// sets the length limit to its maximum. cfg_we_i loads the limit; write it
// only while no string is in flight.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 import jsu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LIM_W-1:0] cfg_wdata_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // in_byte
  input  logic             s_axis_tlast,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // out_byte
  output logic [4:0]       m_axis_tuser,   // status[3:0], byte_valid
  output logic             m_axis_tlast
);

  logic [LIM_W-1:0]   max_q;
  logic               in_valid_q;
  logic [7:0]         in_byte_q;
  logic               in_eoi_q;
  logic               adv;
  logic               room;
  run_t               run;
  logic [RUN_N_W-1:0] run_n;
  res_t               head;

  assign adv           = in_valid_q && room;
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '1;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_eoi_q  <= s_axis_tlast;
    end
  end

  jsu_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .in_byte_i (in_byte_q),
    .eoi_i     (in_eoi_q),
    .max_i     (max_q),
    .run_o     (run),
    .run_n_o   (run_n)
  );

  jsu_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (adv),
    .run_i   (run),
    .run_n_i (run_n),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .head_o  (head)
  );

  assign m_axis_tdata = head.out_byte;
  assign m_axis_tuser = {head.status, head.byte_valid};
  assign m_axis_tlast = head.last;

endmodule
